### rtl/tmhm_pkg.sv
package tmhm_pkg;

   localparam logic [1:0] MODE_LOAD_A = 2'd0;
   localparam logic [1:0] MODE_LOAD_B = 2'd1;
   localparam logic [1:0] MODE_MERGE  = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value_res;
      logic               from_heap_b;
      logic               last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROOTS,
      ST_PICK,
      ST_TAIL,
      ST_LEFT,
      ST_RIGHT,
      ST_DECIDE
   } state_type;

endpackage

### rtl/tmhm_heap_mem.sv
module tmhm_heap_mem #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/two_max_heap_merge_unit.sv
// Two max heaps, A and B, are loaded one element per item (mode 0 or 1), and
// a load into a full heap is dropped. A merge item (mode 2) raises busy and
// drains both heaps, emitting the larger root each time with A winning ties.
// Every result is shown for one cycle on rsp_strobe and the receiver cannot
// stall it, so it must take each result as it comes; no two results fall on
// adjacent cycles and the last one carries the last flag. Each heap lives in
// a memory with one read port and one write port. A result that empties its
// heap takes a root read and a pick. Any other result takes a root read, a
// pick and a tail read, then per sift-down level reads of its children (left,
// then right if present) through the single read port and a write of one
// entry back, plus a final write when the element comes to rest on a leaf.
// A merge on empty heaps leaves busy low and emits nothing.
module two_max_heap_merge_unit
   import tmhm_pkg::*;
#(
   parameter int HEAP_DEPTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int IW = AW + 2;

   state_type          state_ff, state_in;
   logic [CW-1:0]      cnt_a_ff, cnt_a_in;
   logic [CW-1:0]      cnt_b_ff, cnt_b_in;
   logic               sel_ff, sel_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic signed [31:0] p_ff, p_in;
   logic signed [31:0] lval_ff, lval_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_item_ff, rsp_item_in;

   logic               wr_en, wr_b;
   logic [AW-1:0]      wr_addr;
   logic [31:0]        wr_data;
   logic               rd_en_a, rd_en_b;
   logic [AW-1:0]      rd_addr;
   logic [31:0]        rd_data_a, rd_data_b;

   logic [CW-1:0]      size;
   logic [IW-1:0]      size_x, l_idx, r_idx, pick_idx;
   logic signed [31:0] rd_sel, root_a, root_b, pick_val;
   logic               take_b, last, has_r, stop;
   logic [CW-1:0]      cnt_pick, new_size;
   logic [CW:0]        cnt_sum;

   tmhm_heap_mem #(.DEPTH(HEAP_DEPTH), .AW(AW)) u_mem_a (
      .clock   (clock),
      .wr_en   (wr_en && !wr_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en_a),
      .rd_addr (rd_addr),
      .rd_data (rd_data_a)
   );

   tmhm_heap_mem #(.DEPTH(HEAP_DEPTH), .AW(AW)) u_mem_b (
      .clock   (clock),
      .wr_en   (wr_en && wr_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en_b),
      .rd_addr (rd_addr),
      .rd_data (rd_data_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_a_ff      <= cnt_a_in;
         cnt_b_ff      <= cnt_b_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff      <= sel_in;
      pos_ff      <= pos_in;
      p_ff        <= p_in;
      lval_ff     <= lval_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign root_a   = $signed(rd_data_a);
   assign root_b   = $signed(rd_data_b);
   assign size     = sel_ff ? cnt_b_ff : cnt_a_ff;
   assign rd_sel   = sel_ff ? root_b : root_a;
   assign size_x   = {{(IW - CW){1'b0}}, size};
   assign l_idx    = {1'b0, pos_ff, 1'b1};
   assign r_idx    = l_idx + IW'(1);
   assign has_r    = r_idx < size_x;
   assign cnt_sum  = {1'b0, cnt_a_ff} + {1'b0, cnt_b_ff};
   assign last     = cnt_sum == (CW + 1)'(1);
   assign take_b   = (cnt_a_ff != '0 && cnt_b_ff != '0) ? (root_a < root_b)
                                                       : (cnt_a_ff == '0);
   assign cnt_pick = take_b ? cnt_b_ff : cnt_a_ff;
   assign new_size = cnt_pick - CW'(1);

   always_comb begin
      if (has_r) begin
         stop     = (p_ff > lval_ff) && (p_ff > rd_sel);
         pick_idx = (lval_ff > rd_sel) ? l_idx : r_idx;
         pick_val = (lval_ff > rd_sel) ? lval_ff : rd_sel;
      end else begin
         stop     = p_ff > lval_ff;
         pick_idx = l_idx;
         pick_val = lval_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      sel_in        = sel_ff;
      pos_in        = pos_ff;
      p_in          = p_ff;
      lval_in       = lval_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      wr_en         = 1'b0;
      wr_b          = sel_ff;
      wr_addr       = pos_ff;
      wr_data       = p_ff;
      rd_en_a       = 1'b0;
      rd_en_b       = 1'b0;
      rd_addr       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_item.mode)
                  MODE_LOAD_A: begin
                     wr_b    = 1'b0;
                     wr_addr = cnt_a_ff[AW-1:0];
                     wr_data = req_item.value;
                     if (cnt_a_ff < CW'(HEAP_DEPTH)) begin
                        wr_en    = 1'b1;
                        cnt_a_in = cnt_a_ff + CW'(1);
                     end
                  end
                  MODE_LOAD_B: begin
                     wr_b    = 1'b1;
                     wr_addr = cnt_b_ff[AW-1:0];
                     wr_data = req_item.value;
                     if (cnt_b_ff < CW'(HEAP_DEPTH)) begin
                        wr_en    = 1'b1;
                        cnt_b_in = cnt_b_ff + CW'(1);
                     end
                  end
                  MODE_MERGE: begin
                     if (cnt_a_ff != '0 || cnt_b_ff != '0) begin
                        state_in = ST_ROOTS;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ROOTS: begin
            rd_en_a  = 1'b1;
            rd_en_b  = 1'b1;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            rsp_strobe_in           = 1'b1;
            rsp_item_in.value_res   = take_b ? root_b : root_a;
            rsp_item_in.from_heap_b = take_b;
            rsp_item_in.last        = last;
            sel_in                  = take_b;
            pos_in                  = '0;
            if (take_b) begin
               cnt_b_in = new_size;
            end else begin
               cnt_a_in = new_size;
            end
            if (new_size != '0) begin
               rd_en_a  = !take_b;
               rd_en_b  = take_b;
               rd_addr  = new_size[AW-1:0];
               state_in = ST_TAIL;
            end else begin
               state_in = last ? ST_IDLE : ST_ROOTS;
            end
         end
         ST_TAIL: begin
            p_in     = rd_sel;
            state_in = ST_LEFT;
         end
         ST_LEFT: begin
            if (l_idx < size_x) begin
               rd_en_a  = !sel_ff;
               rd_en_b  = sel_ff;
               rd_addr  = l_idx[AW-1:0];
               state_in = ST_RIGHT;
            end else begin
               wr_en    = 1'b1;
               state_in = ST_ROOTS;
            end
         end
         ST_RIGHT: begin
            lval_in  = rd_sel;
            rd_en_a  = has_r && !sel_ff;
            rd_en_b  = has_r && sel_ff;
            rd_addr  = r_idx[AW-1:0];
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            wr_en = 1'b1;
            if (stop) begin
               state_in = ST_ROOTS;
            end else begin
               wr_data  = pick_val;
               pos_in   = pick_idx[AW-1:0];
               state_in = ST_LEFT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

### rtl/tmhm_checker.sv
module tmhm_checker
   import tmhm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   // Results of one merge are never on adjacent cycles.
   a_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results on adjacent cycles");

   // Until the last result of a run has been shown, the block stays busy.
   a_busy_mid_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.last) |-> busy)
      else $error("not busy in the middle of a merge");

   // The last result ends the run and the block is idle at once.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.last) |-> !busy)
      else $error("busy after the last result");

   // A load leaves the block idle, with no result shown, in the next cycle.
   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.mode != MODE_MERGE) |=> (!busy && !rsp_strobe))
      else $error("load did not finish in one cycle");

endmodule

bind two_max_heap_merge_unit tmhm_checker u_tmhm_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

### tb/two_max_heap_merge_unit_test.sv
`timescale 1ns / 1ps

module two_max_heap_merge_unit_test;
   import tmhm_pkg::*;

   localparam int HEAP_DEPTH = 32;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   two_max_heap_merge_unit #(
      .HEAP_DEPTH(HEAP_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

   req_type            item_backlog [$];
   rsp_type            drained_order [$];
   logic signed [31:0] heap_mem [2][HEAP_DEPTH];
   int                 heap_count [2] = '{0, 0};
   int                 stimulus_items = 0;
   int                 accepted_items = 0;
   int                 merge_count = 0;
   int                 checked_results = 0;
   int                 error_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("two_max_heap_merge_unit regression: fail");
      $finish;
   end

   task automatic sift_root(input int h);
      int                 size;
      int                 pos;
      int                 lft;
      int                 rgt;
      int                 pick;
      bit                 done;
      logic signed [31:0] par;
      size = heap_count[h] - 1;
      heap_mem[h][0] = heap_mem[h][size];
      pos = 0;
      done = 1'b0;
      while (!done && pos < size) begin
         lft = 2 * pos + 1;
         rgt = 2 * pos + 2;
         par = heap_mem[h][pos];
         if (rgt < size) begin
            if (par > heap_mem[h][lft] && par > heap_mem[h][rgt]) begin
               done = 1'b1;
            end else begin
               pick = (heap_mem[h][lft] > heap_mem[h][rgt]) ? lft : rgt;
            end
         end else if (lft < size) begin
            if (par > heap_mem[h][lft]) begin
               done = 1'b1;
            end else begin
               pick = lft;
            end
         end else begin
            done = 1'b1;
         end
         if (!done) begin
            heap_mem[h][pos] = heap_mem[h][pick];
            heap_mem[h][pick] = par;
            pos = pick;
         end
      end
      heap_count[h] = size;
   endtask

   task automatic apply_item_to_heaps(input req_type it);
      int      h;
      logic    take_b;
      rsp_type r;
      case (it.mode)
         MODE_LOAD_A, MODE_LOAD_B: begin
            h = (it.mode == MODE_LOAD_B) ? 1 : 0;
            if (heap_count[h] < HEAP_DEPTH) begin
               heap_mem[h][heap_count[h]] = it.value;
               heap_count[h]++;
            end
         end
         MODE_MERGE: begin
            merge_count++;
            while (heap_count[0] != 0 || heap_count[1] != 0) begin
               if (heap_count[0] != 0 && heap_count[1] != 0) begin
                  take_b = heap_mem[0][0] < heap_mem[1][0];
               end else begin
                  take_b = (heap_count[0] == 0);
               end
               h = take_b ? 1 : 0;
               r.value_res = heap_mem[h][0];
               r.from_heap_b = take_b;
               sift_root(h);
               r.last = (heap_count[0] == 0 && heap_count[1] == 0);
               drained_order = {drained_order, r};
            end
         end
         default: begin
         end
      endcase
   endtask

   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 8) - 4;
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7fffffff;
               1: return 32'sh80000000;
               2: return 32'sh00000000;
               default: return 32'shffffffff;
            endcase
         end
         default: return $urandom_range(0, 1000);
      endcase
   endfunction

   task automatic queue_item(input logic [1:0] mode, input logic signed [31:0] value);
      req_type it;
      it.mode = mode;
      it.value = value;
      item_backlog = {item_backlog, it};
      if (mode != MODE_UNUSED) begin
         stimulus_items++;
      end
   endtask

   task automatic queue_heap_pair(input bit shaped);
      logic signed [31:0] vals [2][36];
      logic signed [31:0] tmp;
      int                 n [2];
      int                 sent [2];
      int                 h;
      int                 j;
      for (h = 0; h < 2; h++) begin
         n[h] = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 35) : $urandom_range(0, 8);
         sent[h] = 0;
         for (int k = 0; k < n[h]; k++) begin
            vals[h][k] = rand_value();
            j = k;
            while (shaped && j > 0 && vals[h][(j - 1) / 2] < vals[h][j]) begin
               tmp = vals[h][j];
               vals[h][j] = vals[h][(j - 1) / 2];
               vals[h][(j - 1) / 2] = tmp;
               j = (j - 1) / 2;
            end
         end
      end
      while (sent[0] < n[0] || sent[1] < n[1]) begin
         if (sent[0] == n[0]) begin
            h = 1;
         end else if (sent[1] == n[1]) begin
            h = 0;
         end else begin
            h = $urandom_range(0, 1);
         end
         queue_item((h == 1) ? MODE_LOAD_B : MODE_LOAD_A, vals[h][sent[h]]);
         sent[h]++;
         if ($urandom_range(0, 29) == 0) begin
            queue_item(MODE_UNUSED, $urandom);
         end
      end
      queue_item(MODE_MERGE, $urandom);
   endtask

   always @(posedge clock) begin : driver
      logic idle;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            apply_item_to_heaps(req_item);
            accepted_items++;
         end
         if (!start || !busy) begin
            idle = (accepted_items >= 100 && accepted_items < 170) ? 1'b0
                   : ($urandom_range(0, 99) < 34);
            if (item_backlog.size() != 0 && !idle) begin
               req_item <= item_backlog.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (drained_order.size() == 0) begin
            error_count++;
            $display("%0t: unexpected item: actual value %0d from_heap_b %0b last %0b",
                     $time, rsp_item.value_res, rsp_item.from_heap_b, rsp_item.last);
         end else begin
            want = drained_order.pop_front();
            checked_results++;
            if (rsp_item !== want) begin
               error_count++;
               $display("%0t: mismatch: expected %0d/%0b/%0b, actual %0d/%0b/%0b",
                        $time, want.value_res, want.from_heap_b, want.last,
                        rsp_item.value_res, rsp_item.from_heap_b, rsp_item.last);
            end
         end
      end
   end

   initial begin
      int r;

      // Merge on empty heaps, then an unused mode.
      queue_item(MODE_MERGE, 32'sh0);
      queue_item(MODE_UNUSED, 32'sh7fffffff);
      // Extremes, a tie between roots, and equal children in heap B.
      queue_item(MODE_LOAD_A, 32'sh7fffffff);
      queue_item(MODE_LOAD_A, 32'sh00000000);
      queue_item(MODE_LOAD_A, 32'sh80000000);
      queue_item(MODE_LOAD_B, 32'sh7fffffff);
      queue_item(MODE_LOAD_B, 32'shffffffff);
      queue_item(MODE_LOAD_B, 32'shffffffff);
      queue_item(MODE_LOAD_B, 32'sh80000000);
      queue_item(MODE_MERGE, 32'shffffffff);
      // Data that is not a heap.
      queue_item(MODE_LOAD_A, 32'sh80000000);
      queue_item(MODE_LOAD_A, 32'sh7fffffff);
      queue_item(MODE_LOAD_A, 32'sh00000005);
      queue_item(MODE_LOAD_B, 32'sh00000000);
      queue_item(MODE_MERGE, 32'sh55555555);
      // Only one heap holds data.
      queue_item(MODE_LOAD_B, 32'sh00000003);
      queue_item(MODE_LOAD_B, 32'sh00000003);
      queue_item(MODE_MERGE, 32'shaaaaaaaa);
      queue_item(MODE_LOAD_A, 32'shffffffff);
      queue_item(MODE_MERGE, 32'sh0);

      while (stimulus_items < 240) begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            queue_heap_pair(1'b1);
         end else if (r < 90) begin
            queue_heap_pair(1'b0);
         end else begin
            queue_item(MODE_UNUSED, $urandom);
            queue_item(MODE_MERGE, $urandom);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do begin
         @(posedge clock);
      end while (item_backlog.size() != 0 || start || drained_order.size() != 0);
      repeat (40) @(posedge clock);

      $display("Run covered %0d accepted items including %0d merges; %0d drained items checked.",
               accepted_items, merge_count, checked_results);
      if (error_count == 0) begin
         $display("two_max_heap_merge_unit regression: pass");
      end else begin
         $display("two_max_heap_merge_unit regression: fail");
      end
      $finish;
   end

endmodule
